FILE: hdl/rgb3_pkg.sv
// Shared constants, types and register codes for the RGB 3x3 convolution filter.
`timescale 1ns / 1ps
package rgb3_pkg;

    localparam int KSIZE      = 3;
    localparam int MAX_WIDTH  = 2048;
    localparam int ADDR_W     = $clog2(MAX_WIDTH);
    localparam int PIX_W      = 24;
    localparam int ROW_W      = 12;
    localparam int COL_W      = 11;
    localparam int WID_W      = 12;
    localparam int HGT_W      = 13;
    localparam int COEF_W     = 16;
    localparam int ACC_W      = 28;
    localparam int DIV_STEPS  = ACC_W;
    localparam int DCNT_W     = $clog2(DIV_STEPS);
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 48;

    localparam logic [WID_W-1:0] W_MIN = WID_W'(3);
    localparam logic [WID_W-1:0] W_MAX = WID_W'(MAX_WIDTH);
    localparam logic [HGT_W-1:0] H_MIN = HGT_W'(3);
    localparam logic [HGT_W-1:0] H_MAX = HGT_W'(4096);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_COEF_TOP = 3'd0,
        CFG_COEF_MID = 3'd1,
        CFG_COEF_BOT = 3'd2,
        CFG_DIVISOR  = 3'd3,
        CFG_ROUND_UP = 3'd4,
        CFG_WIDTH    = 3'd5,
        CFG_HEIGHT   = 3'd6
    } t_cfg_idx;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RD1,
        S_RD2,
        S_RD3,
        S_MAC,
        S_DLD,
        S_DIV,
        S_RND,
        S_EMIT1,
        S_EMIT2,
        S_DONE
    } t_state;

    typedef struct packed {
        logic clr;
        logic mac;
        logic div_load;
        logic div_step;
        logic fin;
    } t_lane_ctl;

    typedef struct packed {
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic [PIX_W-1:0] pix;
        logic             use_lanes;
        logic             last;
    } t_beat;

endpackage

FILE: hdl/rgb3_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module rgb3_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 2048
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

FILE: hdl/rgb3_lane.sv
// One color lane: serial multiply-accumulate, bit-serial divide, rounding and clamp.
`timescale 1ns / 1ps
module rgb3_lane (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  rgb3_pkg::t_lane_ctl       i_ctl,
    input  logic [7:0]                i_pix,
    input  logic signed [15:0]        i_weight,
    input  logic [15:0]               i_divisor,
    input  logic                      i_round_up,
    output logic [7:0]                o_value
);
    import rgb3_pkg::*;

    logic signed [ACC_W-1:0] r_acc;
    logic [ACC_W-1:0]        r_mag;
    logic [COEF_W-1:0]       r_rem;
    logic                    r_neg;
    logic [7:0]              r_value;

    logic signed [24:0]      prod;
    logic [COEF_W:0]         rem_sh;
    logic                    q_bit;
    logic signed [ACC_W+1:0] q;
    logic signed [ACC_W+1:0] qf;
    logic [COEF_W-1:0]       rr;
    logic [COEF_W:0]         rr2;
    logic                    inc;
    logic [7:0]              n_value;

    assign prod   = i_weight * $signed({1'b0, i_pix});
    assign rem_sh = {r_rem, r_mag[ACC_W-1]};
    assign q_bit  = (rem_sh >= {1'b0, i_divisor});

    // floor division from magnitude quotient and remainder
    always_comb begin
        if (r_neg && (r_rem != '0)) begin
            q  = -$signed({2'b00, r_mag}) - (ACC_W+2)'(1);
            rr = i_divisor - r_rem;
        end else if (r_neg) begin
            q  = -$signed({2'b00, r_mag});
            rr = r_rem;
        end else begin
            q  = $signed({2'b00, r_mag});
            rr = r_rem;
        end
        rr2 = {rr, 1'b0};
        if (i_round_up) begin
            inc = (rr != '0);
        end else begin
            inc = (rr2 > {1'b0, i_divisor}) || ((rr2 == {1'b0, i_divisor}) && q[0]);
        end
        qf = q + $signed({{(ACC_W+1){1'b0}}, inc});
        if (qf < 0) begin
            n_value = 8'd0;
        end else if (qf > (ACC_W+2)'(255)) begin
            n_value = 8'd255;
        end else begin
            n_value = qf[7:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.clr) begin
            r_acc <= '0;
        end else if (i_ctl.mac) begin
            r_acc <= r_acc + ACC_W'(prod);
        end
        if (i_ctl.div_load) begin
            r_neg <= r_acc[ACC_W-1];
            r_mag <= r_acc[ACC_W-1] ? ACC_W'(-r_acc) : ACC_W'(r_acc);
            r_rem <= '0;
        end else if (i_ctl.div_step) begin
            r_rem <= q_bit ? COEF_W'(rem_sh - {1'b0, i_divisor}) : rem_sh[COEF_W-1:0];
            r_mag <= {r_mag[ACC_W-2:0], q_bit};
        end
        if (!i_rst_n) begin
            r_value <= '0;
        end else if (i_ctl.fin) begin
            r_value <= n_value;
        end
    end

    assign o_value = r_value;
endmodule

FILE: hdl/rgb3_merge.sv
// Output stage: combines lane results or a pass-through pixel into one registered beat.
`timescale 1ns / 1ps
module rgb3_merge (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_load,
    input  rgb3_pkg::t_beat      i_beat,
    input  logic [7:0]           i_red,
    input  logic [7:0]           i_green,
    input  logic [7:0]           i_blue,
    output logic                 o_free,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [47:0]          m_axis_tdata,
    output logic                 m_axis_tlast
);
    import rgb3_pkg::*;

    logic             r_valid;
    logic [47:0]      r_data;
    logic             r_last;
    logic [PIX_W-1:0] pix;

    assign pix    = i_beat.use_lanes ? {i_red, i_green, i_blue} : i_beat.pix;
    assign o_free = !r_valid || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_valid <= 1'b0;
        end
        if (i_load) begin
            r_data <= {1'b0, pix[7:0], pix[15:8], pix[23:16], i_beat.col, i_beat.row};
            r_last <= i_beat.last;
        end
    end

    assign m_axis_tvalid = r_valid;
    assign m_axis_tdata  = r_data;
    assign m_axis_tlast  = r_last;
endmodule

FILE: hdl/rgb_3x3_convolution_filter.sv
// Top level of the streaming RGB 3x3 convolution filter.
//
//  channel   dir  handshake                      payload
//  s_axis    in   s_axis_tvalid/s_axis_tready    tdata red,green,blue; tuser frame_start
//  m_axis    out  m_axis_tvalid/m_axis_tready    tdata row,col,red,green,blue; tlast
//  cfg       in   i_cfg_valid/o_cfg_ready        i_cfg_index, i_cfg_data
//
// One pixel at a time: a pixel with no result runs only the read states, a
// pass-through beat adds an emit state, a convolution adds 9 serial MAC taps,
// a 28-step bit-serial divide in each color lane and rounding, and a second beat
// adds another emit state. Reset is synchronous, active low; line stores are not
// cleared. A beat waits in the output register while the next pixel is taken in;
// the core stalls in an emit state only while that register still holds an untaken beat.
`timescale 1ns / 1ps
module rgb_3x3_convolution_filter (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [23:0]                   s_axis_tdata,  // red[7:0] green[15:8] blue[23:16]
    input  logic [0:0]                    s_axis_tuser,  // frame_start[0]
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // out_row[11:0] out_col[22:12] red[30:23] green[38:31] blue[46:39], pad[47]
    output logic [47:0]                   m_axis_tdata,
    output logic                          m_axis_tlast,   // last_of_item
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [rgb3_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [rgb3_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import rgb3_pkg::*;

    // configuration registers
    logic [47:0]      r_coef_top, r_coef_mid, r_coef_bot;
    logic [15:0]      r_divisor;
    logic             r_round_up;
    logic [WID_W-1:0] r_width;
    logic [HGT_W-1:0] r_height;

    // control
    t_state           r_state, n_state;
    logic [ROW_W-1:0] r_row, r_r, n_r;
    logic [COL_W-1:0] r_col, r_c, n_c;
    logic [PIX_W-1:0] r_cur [KSIZE];
    logic [PIX_W-1:0] r_win [2*KSIZE];
    t_beat            r_beat1, n_beat1;
    logic             r_second, n_second;
    logic [1:0]       r_tx, r_ty;
    logic [DCNT_W-1:0] r_dcnt;

    logic [WID_W-1:0] w_eff;
    logic [HGT_W-1:0] h_eff;
    logic [15:0]      div_eff;
    logic             accept;
    logic             border;
    logic             conv;
    logic             merge_load, merge_free;
    t_beat            merge_beat;
    t_lane_ctl        lane_ctl;
    logic [ADDR_W-1:0] raddr_up, raddr_lo;
    logic             ram_we;
    logic [PIX_W-1:0] up_rdata, lo_rdata;
    logic [PIX_W-1:0] tap_pix;
    logic [47:0]      tap_row;
    logic signed [15:0] tap_w;
    logic [7:0]       lane_val [KSIZE];

    assign o_cfg_ready   = 1'b1;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (r_state == S_IDLE);

    // clamp frame size, guard divisor
    always_comb begin
        if (r_width < W_MIN)      w_eff = W_MIN;
        else if (r_width > W_MAX) w_eff = W_MAX;
        else                      w_eff = r_width;
        if (r_height < H_MIN)      h_eff = H_MIN;
        else if (r_height > H_MAX) h_eff = H_MAX;
        else                       h_eff = r_height;
        div_eff = (r_divisor == '0) ? 16'd1 : r_divisor;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef_top <= '0;
            r_coef_mid <= 48'd65536;
            r_coef_bot <= '0;
            r_divisor  <= 16'd1;
            r_round_up <= 1'b0;
            r_width    <= WID_W'(640);
            r_height   <= HGT_W'(480);
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_COEF_TOP: r_coef_top <= i_cfg_data;
                CFG_COEF_MID: r_coef_mid <= i_cfg_data;
                CFG_COEF_BOT: r_coef_bot <= i_cfg_data;
                CFG_DIVISOR:  r_divisor  <= i_cfg_data[15:0];
                CFG_ROUND_UP: r_round_up <= i_cfg_data[0];
                CFG_WIDTH:    r_width    <= i_cfg_data[WID_W-1:0];
                CFG_HEIGHT:   r_height   <= i_cfg_data[HGT_W-1:0];
                default: ;
            endcase
        end
    end

    // line stores: upper holds line r-2, lower line r-1
    rgb3_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_store_up (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_c),
        .i_wdata (r_cur[1]),
        .i_raddr (raddr_up),
        .o_rdata (up_rdata)
    );

    rgb3_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_store_lo (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_c),
        .i_wdata (r_cur[2]),
        .i_raddr (raddr_lo),
        .o_rdata (lo_rdata)
    );

    // window tap for the current MAC step: columns c-2, c-1 from window, c from cur
    always_comb begin
        if (r_tx == 2'd2) begin
            tap_pix = r_cur[r_ty];
        end else begin
            tap_pix = r_win[3'(r_tx) * 3'd3 + 3'(r_ty)];
        end
        unique case (r_ty)
            2'd0:    tap_row = r_coef_top;
            2'd1:    tap_row = r_coef_mid;
            default: tap_row = r_coef_bot;
        endcase
        tap_w = $signed(tap_row[16*r_tx +: 16]);
    end

    for (genvar ch = 0; ch < KSIZE; ch++) begin : g_lane
        rgb3_lane u_lane (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_ctl      (lane_ctl),
            .i_pix      (tap_pix[PIX_W-1-8*ch -: 8]),
            .i_weight   (tap_w),
            .i_divisor  (div_eff),
            .i_round_up (r_round_up),
            .o_value    (lane_val[ch])
        );
    end

    rgb3_merge u_merge (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_load        (merge_load),
        .i_beat        (merge_beat),
        .i_red         (lane_val[0]),
        .i_green       (lane_val[1]),
        .i_blue        (lane_val[2]),
        .o_free        (merge_free),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    // border test for the result at (r-1, c-1)
    assign border = (r_r == ROW_W'(1)) || ({1'b0, r_r} >= h_eff) || ({1'b0, r_c} >= w_eff);
    assign conv   = (r_c >= COL_W'(2)) && !border;

    always_comb begin
        n_state    = r_state;
        n_r        = r_r;
        n_c        = r_c;
        n_beat1    = r_beat1;
        n_second   = r_second;
        lane_ctl   = '0;
        merge_load = 1'b0;
        merge_beat = r_beat1;
        raddr_up   = r_c;
        raddr_lo   = r_c;
        ram_we     = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_r     = s_axis_tuser[0] ? '0 : r_row;
                    n_c     = s_axis_tuser[0] ? '0 : r_col;
                    n_state = S_RD1;
                end
            end
            S_RD1: begin
                n_state = S_RD2;
            end
            S_RD2: begin
                raddr_lo = ADDR_W'(w_eff - WID_W'(1));
                n_state  = S_RD3;
            end
            S_RD3: begin
                ram_we           = 1'b1;
                lane_ctl.clr     = 1'b1;
                n_second         = (({1'b0, r_r} + HGT_W'(1)) >= h_eff);
                n_beat1.row      = r_r - ROW_W'(1);
                n_beat1.last     = !n_second;
                n_beat1.use_lanes = conv;
                if (r_c == '0) begin
                    n_beat1.col = '0;
                    n_beat1.pix = r_cur[1];
                end else if (r_c == COL_W'(1)) begin
                    n_beat1.col = COL_W'(w_eff - WID_W'(1));
                    n_beat1.pix = lo_rdata;
                end else begin
                    n_beat1.col = r_c - COL_W'(1);
                    n_beat1.pix = r_win[4];
                end
                if (r_r == '0)  n_state = S_DONE;
                else if (conv)  n_state = S_MAC;
                else            n_state = S_EMIT1;
            end
            S_MAC: begin
                lane_ctl.mac = 1'b1;
                if (r_tx == 2'd2 && r_ty == 2'd2) n_state = S_DLD;
            end
            S_DLD: begin
                lane_ctl.div_load = 1'b1;
                n_state = S_DIV;
            end
            S_DIV: begin
                lane_ctl.div_step = 1'b1;
                if (r_dcnt == DCNT_W'(DIV_STEPS - 1)) n_state = S_RND;
            end
            S_RND: begin
                lane_ctl.fin = 1'b1;
                n_state = S_EMIT1;
            end
            S_EMIT1: begin
                if (merge_free) begin
                    merge_load = 1'b1;
                    n_state    = r_second ? S_EMIT2 : S_DONE;
                end
            end
            S_EMIT2: begin
                merge_beat.row       = r_r;
                merge_beat.col       = r_c;
                merge_beat.pix       = r_cur[2];
                merge_beat.use_lanes = 1'b0;
                merge_beat.last      = 1'b1;
                if (merge_free) begin
                    merge_load = 1'b1;
                    n_state    = S_DONE;
                end
            end
            S_DONE: begin
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_row   <= '0;
            r_col   <= '0;
            r_tx    <= '0;
            r_ty    <= '0;
            r_dcnt  <= '0;
            for (int i = 0; i < 2*KSIZE; i++) r_win[i] <= '0;
        end else begin
            r_state <= n_state;
            // tap walk, row by row
            if (r_state == S_MAC) begin
                if (r_tx == 2'd2) begin
                    r_tx <= '0;
                    r_ty <= (r_ty == 2'd2) ? 2'd0 : r_ty + 2'd1;
                end else begin
                    r_tx <= r_tx + 2'd1;
                end
            end
            if (r_state == S_DIV) r_dcnt <= r_dcnt + DCNT_W'(1);
            else                  r_dcnt <= '0;
            if (r_state == S_DONE) begin
                for (int i = 0; i < KSIZE; i++) begin
                    r_win[i]       <= r_win[KSIZE+i];
                    r_win[KSIZE+i] <= r_cur[i];
                end
                if (({1'b0, r_c} + WID_W'(1)) >= w_eff) begin
                    r_col <= '0;
                    r_row <= (({1'b0, r_r} + HGT_W'(1)) >= h_eff) ? '0 : r_r + ROW_W'(1);
                end else begin
                    r_col <= r_c + COL_W'(1);
                    r_row <= r_r;
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_r      <= n_r;
        r_c      <= n_c;
        r_beat1  <= n_beat1;
        r_second <= n_second;
        if (accept) begin
            r_cur[2] <= {s_axis_tdata[7:0], s_axis_tdata[15:8], s_axis_tdata[23:16]};
        end
        if (r_state == S_RD2) begin
            r_cur[0] <= up_rdata;
            r_cur[1] <= lo_rdata;
        end
    end
endmodule

FILE: hdl/rgb3_checker.sv
// Port-level checks for the RGB 3x3 convolution filter, bound to the top level.
`timescale 1ns / 1ps
module rgb3_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [47:0] m_axis_tdata,
    input logic        m_axis_tlast
);
    // a taken pixel blocks input for at least the next cycle
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input ready right after a pixel was taken");

    // a stalled beat holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tlast))
        else $error("output beat changed under stall");

    // no beat right out of reset
    a_reset_clean: assert property (@(posedge i_clk)
        i_rst_n && $past(!i_rst_n) |-> !m_axis_tvalid)
        else $error("output valid right after reset");

    // pad bit stays clear
    a_pad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !m_axis_tdata[47])
        else $error("tdata pad bit set");
endmodule

bind rgb_3x3_convolution_filter rgb3_checker u_rgb3_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);
